// ===== hdl/ptc_pkg.sv =====
// ----------------------------------------------------------------------------
// Pressure/temperature compensation package
// Shared widths, register indexes and the pipeline control bundle.
// ----------------------------------------------------------------------------
package ptc_pkg;

   // Number of register stages from input transfer to result register.
   localparam int NUM_STAGES = 11;

   // Configuration port geometry.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Register indexes of the calibration words.
   localparam logic [CSR_INDEX_W-1:0] REG_SENS_GAIN        = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_OFFSET_BASE      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SENS_TEMP_COEF   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_OFFSET_TEMP_COEF = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_REF_TEMP_CODE    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_TEMP_GAIN        = 3'd5;

   // Per-stage load enables and occupancy flags.
   typedef struct packed {
      logic [NUM_STAGES-1:0] en;
      logic [NUM_STAGES-1:0] valid;
   } ptc_pipe_type;

endpackage

// ===== hdl/ptc_pipe_ctrl.sv =====
// ----------------------------------------------------------------------------
// Pipeline control
// Tracks stage occupancy and gives each stage its own load enable, so that
// empty stages fill up while the result register is stalled.
// ----------------------------------------------------------------------------
module ptc_pipe_ctrl
   import ptc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  logic         out_ready,
   output logic         in_ready,
   output ptc_pipe_type pipe
);

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] en;

   // A stage loads when it is empty or when its successor loads.
   always_comb begin
      en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || out_ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   // Next occupancy of every stage.
   always_comb begin
      valid_in[0] = en[0] ? in_valid : valid_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = en[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready   = en[0];
   assign pipe.en    = en;
   assign pipe.valid = valid_ff;

endmodule

// ===== hdl/pressure_temp_compensation.sv =====
// Throughput: one reading pair per cycle; the eleven-stage multiply and
// correction pipeline accepts a new pair every cycle unless stalled.
// A stalled result register lets empty stages behind it keep filling.
// Reset (synchronous, active high) empties the pipeline and clears all six
// calibration words to zero.
// ----------------------------------------------------------------------------
// Pressure/temperature compensation
// Second-order compensation of a raw temperature and pressure reading pair
// using six calibration words, pipelined over eleven register stages.
// ----------------------------------------------------------------------------
module pressure_temp_compensation
   import ptc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // Calibration write port.
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   // Reading pairs.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [47:0]            req_tdata,  // raw_temperature[23:0], raw_pressure[47:24]
   // Compensated results.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [55:0]            rsp_tdata   // temperature[18:0], pressure[50:19], zeros
);

   ptc_pipe_type ctl;

   // ------------------------------------------------------------------------
   // Calibration registers
   // ------------------------------------------------------------------------
   logic [15:0] c1_ff, c2_ff, c3_ff, c4_ff, c5_ff, c6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff <= '0;
         c2_ff <= '0;
         c3_ff <= '0;
         c4_ff <= '0;
         c5_ff <= '0;
         c6_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_SENS_GAIN:        c1_ff <= csr_wdata;
            REG_OFFSET_BASE:      c2_ff <= csr_wdata;
            REG_SENS_TEMP_COEF:   c3_ff <= csr_wdata;
            REG_OFFSET_TEMP_COEF: c4_ff <= csr_wdata;
            REG_REF_TEMP_CODE:    c5_ff <= csr_wdata;
            REG_TEMP_GAIN:        c6_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Pipeline control
   // ------------------------------------------------------------------------
   ptc_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .out_ready (rsp_tready),
      .in_ready  (req_tready),
      .pipe      (ctl)
   );

   // ------------------------------------------------------------------------
   // Stage 1: temperature difference from the reference.
   // ------------------------------------------------------------------------
   logic signed [24:0] dt1_in, dt1_ff;
   logic        [23:0] d1_1_ff;

   assign dt1_in = $signed({1'b0, req_tdata[23:0]}) - $signed({1'b0, c5_ff, 8'd0});

   always_ff @(posedge clock) begin
      if (ctl.en[0]) begin
         dt1_ff  <= dt1_in;
         d1_1_ff <= req_tdata[47:24];
      end
   end

   // ------------------------------------------------------------------------
   // Stage 2: the four independent products of the difference.
   // ------------------------------------------------------------------------
   logic signed [41:0] p6_ff, p4_ff, p3_ff;
   logic signed [49:0] dtsq_ff;
   logic        [23:0] d1_2_ff;

   always_ff @(posedge clock) begin
      if (ctl.en[1]) begin
         p6_ff   <= dt1_ff * $signed({1'b0, c6_ff});
         p4_ff   <= $signed({1'b0, c4_ff}) * dt1_ff;
         p3_ff   <= $signed({1'b0, c3_ff}) * dt1_ff;
         dtsq_ff <= dt1_ff * dt1_ff;
         d1_2_ff <= d1_1_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 3: first-order temperature, temperature correction and the
   // first-order offset and sensitivity.
   // ------------------------------------------------------------------------
   logic signed [18:0] temp3_in, temp3_ff;
   logic signed [18:0] dev3_ff, cold3_ff;
   logic        [48:0] dtsq_u;
   logic        [17:0] t2_below;
   logic        [51:0] dtsq7;
   logic        [17:0] t2_in, t2_3_ff;
   logic signed [36:0] offb3_in, offb3_ff;
   logic signed [35:0] sensb3_in, sensb3_ff;
   logic        [23:0] d1_3_ff;

   always_comb begin
      temp3_in  = $signed(p6_ff[41:23]) + 19'sd2000;
      dtsq_u    = dtsq_ff[48:0];
      t2_below  = {2'b00, dtsq_u[48:33]} + {1'b0, dtsq_u[48:33], 1'b0};
      dtsq7     = {dtsq_u, 3'b000} - {3'b000, dtsq_u};
      t2_in     = (temp3_in < 19'sd2000) ? t2_below : {3'b000, dtsq7[51:37]};
      offb3_in  = $signed({5'b00000, c2_ff, 16'd0})
                + $signed({{2{p4_ff[41]}}, p4_ff[41:7]});
      sensb3_in = $signed({5'b00000, c1_ff, 15'd0})
                + $signed({{2{p3_ff[41]}}, p3_ff[41:8]});
   end

   always_ff @(posedge clock) begin
      if (ctl.en[2]) begin
         temp3_ff  <= temp3_in;
         dev3_ff   <= temp3_in - 19'sd2000;
         cold3_ff  <= temp3_in + 19'sd1500;
         t2_3_ff   <= t2_in;
         offb3_ff  <= offb3_in;
         sensb3_ff <= sensb3_in;
         d1_3_ff   <= d1_2_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 4: squares of the deviations and the final temperature.
   // ------------------------------------------------------------------------
   logic signed [37:0] sq4_full, csq4_full;
   logic        [35:0] sq4_ff, csq4_ff;
   logic               warm_lt4_ff, cold_lt4_ff;
   logic signed [18:0] tout4_ff;
   logic signed [36:0] offb4_ff;
   logic signed [35:0] sensb4_ff;
   logic        [23:0] d1_4_ff;

   assign sq4_full  = dev3_ff * dev3_ff;
   assign csq4_full = cold3_ff * cold3_ff;

   always_ff @(posedge clock) begin
      if (ctl.en[3]) begin
         sq4_ff      <= sq4_full[35:0];
         csq4_ff     <= csq4_full[35:0];
         warm_lt4_ff <= dev3_ff[18];
         cold_lt4_ff <= cold3_ff[18];
         tout4_ff    <= temp3_ff - $signed({1'b0, t2_3_ff});
         offb4_ff    <= offb3_ff;
         sensb4_ff   <= sensb3_ff;
         d1_4_ff     <= d1_3_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 5: second-order offset and sensitivity corrections.
   // ------------------------------------------------------------------------
   logic [37:0] sq3x;
   logic [38:0] sq5x, csq7x, csq4x;
   logic [38:0] off2_in, sens2_in, off2_ff, sens2_ff;
   logic signed [18:0] tout5_ff;
   logic signed [36:0] offb5_ff;
   logic signed [35:0] sensb5_ff;
   logic        [23:0] d1_5_ff;

   always_comb begin
      sq3x  = {2'b00, sq4_ff} + {1'b0, sq4_ff, 1'b0};
      sq5x  = {3'b000, sq4_ff} + {1'b0, sq4_ff, 2'b00};
      csq7x = {csq4_ff, 3'b000} - {3'b000, csq4_ff};
      csq4x = {1'b0, csq4_ff, 2'b00};
      if (warm_lt4_ff) begin
         off2_in  = {2'b00, sq3x[37:1]};
         sens2_in = {3'b000, sq5x[38:3]};
         // Extra terms in the very cold range.
         if (cold_lt4_ff) begin
            off2_in  = off2_in + csq7x;
            sens2_in = sens2_in + csq4x;
         end
      end else begin
         off2_in  = {7'd0, sq4_ff[35:4]};
         sens2_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en[4]) begin
         off2_ff   <= off2_in;
         sens2_ff  <= sens2_in;
         tout5_ff  <= tout4_ff;
         offb5_ff  <= offb4_ff;
         sensb5_ff <= sensb4_ff;
         d1_5_ff   <= d1_4_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 6: corrected offset and sensitivity.
   // ------------------------------------------------------------------------
   logic signed [39:0] off6_ff, sens6_full;
   logic signed [37:0] sens6_ff;
   logic signed [18:0] tout6_ff;
   logic        [23:0] d1_6_ff;

   assign sens6_full = $signed({{4{sensb5_ff[35]}}, sensb5_ff}) - $signed({1'b0, sens2_ff});

   always_ff @(posedge clock) begin
      if (ctl.en[5]) begin
         off6_ff  <= $signed({{3{offb5_ff[36]}}, offb5_ff}) - $signed({1'b0, off2_ff});
         sens6_ff <= sens6_full[37:0];
         tout6_ff <= tout5_ff;
         d1_6_ff  <= d1_5_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 7: sensitivity times raw pressure as two partial products.
   // ------------------------------------------------------------------------
   logic        [42:0] pplo7_ff;
   logic signed [43:0] pphi7_ff;
   logic signed [39:0] off7_ff;
   logic signed [18:0] tout7_ff;

   always_ff @(posedge clock) begin
      if (ctl.en[6]) begin
         pplo7_ff <= sens6_ff[18:0] * d1_6_ff;
         pphi7_ff <= $signed(sens6_ff[37:19]) * $signed({1'b0, d1_6_ff});
         off7_ff  <= off6_ff;
         tout7_ff <= tout6_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 8: combine the partial products.
   // ------------------------------------------------------------------------
   logic signed [62:0] prod8_ff;
   logic signed [39:0] off8_ff;
   logic signed [18:0] tout8_ff;

   always_ff @(posedge clock) begin
      if (ctl.en[7]) begin
         prod8_ff <= $signed({pphi7_ff, 19'd0}) + $signed({20'd0, pplo7_ff});
         off8_ff  <= off7_ff;
         tout8_ff <= tout7_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 9: divide by 2^21, truncating toward zero.
   // ------------------------------------------------------------------------
   logic signed [62:0] prod_biased;
   logic signed [41:0] q9_ff;
   logic signed [39:0] off9_ff;
   logic signed [18:0] tout9_ff;

   assign prod_biased = prod8_ff + $signed({42'd0, {21{prod8_ff[62]}}});

   always_ff @(posedge clock) begin
      if (ctl.en[8]) begin
         q9_ff    <= prod_biased[62:21];
         off9_ff  <= off8_ff;
         tout9_ff <= tout8_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 10: remove the offset.
   // ------------------------------------------------------------------------
   logic signed [42:0] diff10_ff;
   logic signed [18:0] tout10_ff;

   always_ff @(posedge clock) begin
      if (ctl.en[9]) begin
         diff10_ff <= $signed({q9_ff[41], q9_ff}) - $signed({{3{off9_ff[39]}}, off9_ff});
         tout10_ff <= tout9_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 11: divide by 2^15 toward zero into the result register.
   // ------------------------------------------------------------------------
   logic signed [42:0] diff_biased;
   logic        [31:0] pres_ff;
   logic        [18:0] temp_ff;

   assign diff_biased = diff10_ff + $signed({28'd0, {15{diff10_ff[42]}}});

   always_ff @(posedge clock) begin
      if (ctl.en[10]) begin
         pres_ff <= {{4{diff_biased[42]}}, diff_biased[42:15]};
         temp_ff <= tout10_ff;
      end
   end

   assign rsp_tvalid = ctl.valid[NUM_STAGES-1];
   assign rsp_tdata  = {5'd0, pres_ff, temp_ff};

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
`ifndef SYNTHESIS
   // Input backpressure only when every stage holds an item.
   a_full_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (&ctl.valid))
      else $error("input stalled while the pipeline has an empty stage");

   // An accepted pair occupies the first stage on the next cycle.
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> ctl.valid[0])
      else $error("accepted pair did not enter the first stage");

   // No result is offered right after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result offered after reset");
`endif

endmodule
